@@ sv/tcc_pkg.sv @@
`default_nettype none
package tcc_pkg;

  localparam int GLYPH_HEIGHT_DEF = 16;
  localparam int GLYPH_WIDTH      = 8;

  localparam int CHAR_W  = 8;
  localparam int COL_W   = 9;
  localparam int ROW_W   = 8;
  localparam int COLS_W  = 10;
  localparam int ROWS_W  = 9;
  localparam int PITCH_W = 14;
  localparam int FA_W    = 12;
  localparam int FB_W    = 24;
  localparam int IDX_W   = 4;
  localparam int DATA_W  = 14;

  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'd9;
  localparam logic [COLS_W-1:0] TAB_STEP     = 10'd8;

  localparam logic [COLS_W-1:0]  COLS_MAX = 10'd512;
  localparam logic [ROWS_W-1:0]  ROWS_MAX = 9'd256;

  localparam logic [COLS_W-1:0]  COLUMNS_RST = 10'd80;
  localparam logic [ROWS_W-1:0]  ROWS_RST    = 9'd25;
  localparam logic [PITCH_W-1:0] PITCH_RST   = 14'd1024;

  typedef enum logic [IDX_W-1:0] {
    REG_ENABLE  = 4'd0,
    REG_COLUMNS = 4'd1,
    REG_ROWS    = 4'd2,
    REG_PITCH   = 4'd3
  } reg_idx_t;

  typedef enum logic {
    KIND_DRAW   = 1'b0,
    KIND_SCROLL = 1'b1
  } kind_t;

  typedef struct packed {
    logic            draw;
    logic            scroll;
    logic [FA_W-1:0] fa_base;
    logic [FB_W-1:0] fb_base;
  } job_t;

endpackage
`default_nettype wire

@@ sv/tcc_cursor.sv @@
`default_nettype none
module tcc_cursor #(
  parameter int GLYPH_HEIGHT = tcc_pkg::GLYPH_HEIGHT_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        step,
  input  wire logic [tcc_pkg::CHAR_W-1:0]  char_code,
  input  wire logic [tcc_pkg::COLS_W-1:0]  columns,
  input  wire logic [tcc_pkg::ROWS_W-1:0]  rows,
  input  wire logic [tcc_pkg::PITCH_W-1:0] pitch_words,
  output tcc_pkg::job_t                    job
);

  logic [tcc_pkg::COL_W-1:0]   cursor_col, cursor_col_next;
  logic [tcc_pkg::ROW_W-1:0]   cursor_row, cursor_row_next;
  logic [tcc_pkg::COLS_W-1:0]  eff_cols, col_step;
  logic [tcc_pkg::ROWS_W-1:0]  eff_rows, row_inc;
  logic [tcc_pkg::FA_W-1:0]    row_line;
  logic [tcc_pkg::FA_W+tcc_pkg::PITCH_W-1:0] prod;
  logic                        is_nl, is_tab, wrap, row_over;

  always_comb begin
    eff_cols = (columns == '0) ? tcc_pkg::COLS_W'(1) :
               (columns > tcc_pkg::COLS_MAX) ? tcc_pkg::COLS_MAX : columns;
    eff_rows = (rows == '0) ? tcc_pkg::ROWS_W'(1) :
               (rows > tcc_pkg::ROWS_MAX) ? tcc_pkg::ROWS_MAX : rows;
    is_nl    = (char_code == tcc_pkg::CHAR_NEWLINE);
    is_tab   = (char_code == tcc_pkg::CHAR_TAB);
    col_step = tcc_pkg::COLS_W'(cursor_col) +
               (is_tab ? tcc_pkg::TAB_STEP : tcc_pkg::COLS_W'(1));
    wrap     = is_nl || (col_step >= eff_cols);
    row_inc  = tcc_pkg::ROWS_W'(cursor_row) + tcc_pkg::ROWS_W'(1);
    row_over = row_inc >= eff_rows;

    cursor_col_next = wrap ? '0 : col_step[tcc_pkg::COL_W-1:0];
    cursor_row_next = cursor_row;
    if (wrap) begin
      cursor_row_next = row_over ? tcc_pkg::ROW_W'(eff_rows - tcc_pkg::ROWS_W'(1))
                                 : row_inc[tcc_pkg::ROW_W-1:0];
    end

    row_line = tcc_pkg::FA_W'(cursor_row) * tcc_pkg::FA_W'(GLYPH_HEIGHT);
    prod     = (tcc_pkg::FA_W+tcc_pkg::PITCH_W)'(row_line) *
               (tcc_pkg::FA_W+tcc_pkg::PITCH_W)'(pitch_words);

    job.draw    = !is_nl && !is_tab;
    job.scroll  = wrap && row_over;
    job.fa_base = tcc_pkg::FA_W'(char_code) * tcc_pkg::FA_W'(GLYPH_HEIGHT);
    job.fb_base = prod[tcc_pkg::FB_W-1:0] +
                  tcc_pkg::FB_W'({cursor_col, 3'b000});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
    end else if (step) begin
      cursor_col <= cursor_col_next;
      cursor_row <= cursor_row_next;
    end
  end

endmodule
`default_nettype wire

@@ sv/text_console_cursor_blitter_top.sv @@
// An input beat loads the emitter, whose results are then registered to the output.
// Throughput: one result per cycle while out_ready holds. A drawn character gives
// GLYPH_HEIGHT results, and every item that scrolls adds one scroll result.
// The next input beat is taken in the cycle the previous item's last result loads.
// Reset (synchronous): cursor to column 0 row 0, registers to their defaults
// (disabled, 80 columns, 25 rows, pitch 1024), no result pending.
`default_nettype none
module text_console_cursor_blitter_top #(
  parameter int GLYPH_HEIGHT = tcc_pkg::GLYPH_HEIGHT_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output      logic                        cfg_ready,
  input  wire logic [tcc_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [tcc_pkg::DATA_W-1:0]  cfg_data,
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire logic [tcc_pkg::CHAR_W-1:0]  char_code,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic                        kind,
  output      logic [tcc_pkg::FA_W-1:0]    font_addr,
  output      logic [tcc_pkg::FB_W-1:0]    fb_offset,
  output      logic                        last
);

  localparam int CNT_W = $clog2(GLYPH_HEIGHT + 1);

  logic                        enable;
  logic [tcc_pkg::COLS_W-1:0]  columns;
  logic [tcc_pkg::ROWS_W-1:0]  rows;
  logic [tcc_pkg::PITCH_W-1:0] pitch_words;

  tcc_pkg::job_t               job;
  logic [CNT_W-1:0]            em_cnt;
  logic                        em_scroll;
  logic [tcc_pkg::FA_W-1:0]    em_fa;
  logic [tcc_pkg::FB_W-1:0]    em_fb;
  logic                        em_busy, em_fire, em_last, in_beat, step, load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable      <= 1'b0;
      columns     <= tcc_pkg::COLUMNS_RST;
      rows        <= tcc_pkg::ROWS_RST;
      pitch_words <= tcc_pkg::PITCH_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tcc_pkg::REG_ENABLE:  enable      <= cfg_data[0];
        tcc_pkg::REG_COLUMNS: columns     <= cfg_data[tcc_pkg::COLS_W-1:0];
        tcc_pkg::REG_ROWS:    rows        <= cfg_data[tcc_pkg::ROWS_W-1:0];
        tcc_pkg::REG_PITCH:   pitch_words <= cfg_data[tcc_pkg::PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  assign em_busy  = (em_cnt != '0) || em_scroll;
  assign em_fire  = em_busy && (!out_valid || out_ready);
  assign em_last  = (em_cnt == '0) || ((em_cnt == CNT_W'(1)) && !em_scroll);
  assign in_ready = !em_busy || (em_fire && em_last);
  assign in_beat  = in_valid && in_ready;
  assign step     = in_beat && enable;
  assign load     = step && (job.draw || job.scroll);

  tcc_cursor #(
    .GLYPH_HEIGHT(GLYPH_HEIGHT)
  ) u_cursor (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .char_code  (char_code),
    .columns    (columns),
    .rows       (rows),
    .pitch_words(pitch_words),
    .job        (job)
  );

  // advance the emitter one result per beat; a new job overrides the finished one
  always_ff @(posedge clk) begin
    if (rst) begin
      em_cnt    <= '0;
      em_scroll <= 1'b0;
    end else if (load) begin
      em_cnt    <= job.draw ? CNT_W'(GLYPH_HEIGHT) : '0;
      em_scroll <= job.scroll;
    end else if (em_fire) begin
      if (em_cnt != '0) begin
        em_cnt <= em_cnt - CNT_W'(1);
      end else begin
        em_scroll <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      em_fa <= job.fa_base;
      em_fb <= job.fb_base;
    end else if (em_fire && (em_cnt != '0)) begin
      em_fa <= em_fa + tcc_pkg::FA_W'(1);
      em_fb <= em_fb + tcc_pkg::FB_W'(pitch_words);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (em_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (em_fire) begin
      if (em_cnt != '0) begin
        kind      <= tcc_pkg::KIND_DRAW;
        font_addr <= em_fa;
        fb_offset <= em_fb;
      end else begin
        kind      <= tcc_pkg::KIND_SCROLL;
        font_addr <= '0;
        fb_offset <= '0;
      end
      last <= em_last;
    end
  end

endmodule
`default_nettype wire

@@ sv/tcc_checker.sv @@
`default_nettype none
module tcc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        kind,
  input wire logic [11:0] font_addr,
  input wire logic [23:0] fb_offset,
  input wire logic        last
);

  a_scroll_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == tcc_pkg::KIND_SCROLL) |-> (font_addr == '0 && fb_offset == '0))
    else $error("scroll beat carries an address");

  a_scroll_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == tcc_pkg::KIND_SCROLL) |-> last)
    else $error("scroll beat not marked last");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(kind) && $stable(font_addr)
                                   && $stable(fb_offset) && $stable(last)))
    else $error("stalled result beat changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind text_console_cursor_blitter_top tcc_checker u_tcc_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .kind     (kind),
  .font_addr(font_addr),
  .fb_offset(fb_offset),
  .last     (last)
);
`default_nettype wire

@@ dv/tb_text_console_cursor_blitter_top.sv @@
`timescale 1ns / 100ps
module tb_text_console_cursor_blitter_top;

  localparam int GLYPH_H = tcc_pkg::GLYPH_HEIGHT_DEF;

  typedef struct {
    tcc_pkg::kind_t                kind;
    logic [tcc_pkg::FA_W-1:0]      font_addr;
    logic [tcc_pkg::FB_W-1:0]      fb_offset;
    logic                          is_last;
  } glyph_cmd_t;

  typedef struct {
    tcc_pkg::reg_idx_t             idx;
    logic [tcc_pkg::DATA_W-1:0]    data;
  } reg_write_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [tcc_pkg::IDX_W-1:0]       cfg_index = '0;
  logic [tcc_pkg::DATA_W-1:0]      cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [tcc_pkg::CHAR_W-1:0]      char_code = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            kind;
  logic [tcc_pkg::FA_W-1:0]        font_addr;
  logic [tcc_pkg::FB_W-1:0]        fb_offset;
  logic                            last;

  logic [tcc_pkg::CHAR_W-1:0]      char_q[$];
  reg_write_t                      reg_q[$];
  glyph_cmd_t                      cmd_q[$];
  int                              fail_count = 0;

  logic                            con_enable;
  logic [tcc_pkg::COLS_W-1:0]      con_columns;
  logic [tcc_pkg::ROWS_W-1:0]      con_rows;
  logic [tcc_pkg::PITCH_W-1:0]     con_pitch;
  logic [tcc_pkg::COL_W-1:0]       cur_col;
  logic [tcc_pkg::ROW_W-1:0]       cur_row;

  int                              in_wait = 0;
  int                              stall_left = 0;
  bit                              in_calm = 1'b0;
  bit                              out_calm = 1'b0;

  text_console_cursor_blitter_top #(.GLYPH_HEIGHT(GLYPH_H)) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_code (char_code),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .font_addr (font_addr),
    .fb_offset (fb_offset),
    .last      (last)
  );

  always #10 clk = ~clk;

  function automatic int pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  function automatic bit advance_row();
    int unsigned nrows;
    nrows = (con_rows == 0) ? 1 :
            (con_rows > tcc_pkg::ROWS_MAX) ? tcc_pkg::ROWS_MAX : con_rows;
    if (cur_row + 1 >= nrows) begin
      cur_row = tcc_pkg::ROW_W'(nrows - 1);
      return 1'b1;
    end
    cur_row = cur_row + 1'b1;
    return 1'b0;
  endfunction

  task automatic apply_reg(input logic [tcc_pkg::IDX_W-1:0] idx,
                           input logic [tcc_pkg::DATA_W-1:0] data);
    unique case (tcc_pkg::reg_idx_t'(idx))
      tcc_pkg::REG_ENABLE: begin
        con_enable = data[0];
      end
      tcc_pkg::REG_COLUMNS: begin
        con_columns = data[tcc_pkg::COLS_W-1:0];
      end
      tcc_pkg::REG_ROWS: begin
        con_rows = data[tcc_pkg::ROWS_W-1:0];
      end
      tcc_pkg::REG_PITCH: begin
        con_pitch = data[tcc_pkg::PITCH_W-1:0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic predict_glyph_cmds(input logic [tcc_pkg::CHAR_W-1:0] ch);
    glyph_cmd_t  cmds[$];
    glyph_cmd_t  cmd;
    int unsigned ncols;
    int unsigned next_col;
    int unsigned offs;
    bit          scroll;
    if (!con_enable) return;
    ncols = (con_columns == 0) ? 1 :
            (con_columns > tcc_pkg::COLS_MAX) ? tcc_pkg::COLS_MAX : con_columns;
    scroll = 1'b0;
    if (ch == tcc_pkg::CHAR_NEWLINE) begin
      cur_col = '0;
      scroll = advance_row();
    end else begin
      if (ch == tcc_pkg::CHAR_TAB) begin
        next_col = cur_col + tcc_pkg::TAB_STEP;
      end else begin
        for (int r = 0; r < GLYPH_H; r++) begin
          offs = (cur_row * GLYPH_H + r) * con_pitch + cur_col * tcc_pkg::GLYPH_WIDTH;
          cmd.kind      = tcc_pkg::KIND_DRAW;
          cmd.font_addr = tcc_pkg::FA_W'(ch * GLYPH_H + r);
          cmd.fb_offset = tcc_pkg::FB_W'(offs);
          cmd.is_last   = 1'b0;
          cmds.push_back(cmd);
        end
        next_col = cur_col + 1;
      end
      if (next_col >= ncols) begin
        cur_col = '0;
        scroll = advance_row();
      end else begin
        cur_col = tcc_pkg::COL_W'(next_col);
      end
    end
    if (scroll) begin
      cmd.kind      = tcc_pkg::KIND_SCROLL;
      cmd.font_addr = '0;
      cmd.fb_offset = '0;
      cmd.is_last   = 1'b0;
      cmds.push_back(cmd);
    end
    if (cmds.size() > 0) cmds[cmds.size()-1].is_last = 1'b1;
    foreach (cmds[i]) cmd_q.push_back(cmds[i]);
  endtask

  always @(posedge clk) begin : drive_chars
    logic send;
    if (rst) begin
      in_valid  <= 1'b0;
      char_code <= '0;
      in_wait = 0;
    end else begin
      send = in_valid && !in_ready;
      if (!send) begin
        if (in_wait > 0) begin
          in_wait--;
        end else if (char_q.size() > 0) begin
          char_code <= char_q.pop_front();
          send = 1'b1;
          if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
          in_wait = in_calm ? 0 : pick_gap();
        end
      end
      in_valid <= send;
    end
  end

  always @(posedge clk) begin : drive_regs
    logic       send;
    reg_write_t w;
    if (rst) begin
      cfg_valid <= 1'b0;
      cfg_index <= '0;
      cfg_data  <= '0;
    end else begin
      send = cfg_valid && !cfg_ready;
      if (!send && reg_q.size() > 0) begin
        w = reg_q.pop_front();
        cfg_index <= w.idx;
        cfg_data  <= w.data;
        send = 1'b1;
      end
      cfg_valid <= send;
    end
  end

  always @(posedge clk) begin : drive_ready
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!out_calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : watch
    glyph_cmd_t want;
    if (rst) begin
      con_enable  = 1'b0;
      con_columns = tcc_pkg::COLUMNS_RST;
      con_rows    = tcc_pkg::ROWS_RST;
      con_pitch   = tcc_pkg::PITCH_RST;
      cur_col     = '0;
      cur_row     = '0;
      cmd_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) predict_glyph_cmds(char_code);
      if (out_valid && out_ready) begin
        if (cmd_q.size() == 0) begin
          $error("unexpected beat: kind %0d font_addr %0d fb_offset %0d last %0d",
                 kind, font_addr, fb_offset, last);
          fail_count++;
        end else begin
          want = cmd_q.pop_front();
          if (kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind);
            fail_count++;
          end
          if (font_addr !== want.font_addr) begin
            $error("font_addr: expected %0d, got %0d", want.font_addr, font_addr);
            fail_count++;
          end
          if (fb_offset !== want.fb_offset) begin
            $error("fb_offset: expected %0d, got %0d", want.fb_offset, fb_offset);
            fail_count++;
          end
          if (last !== want.is_last) begin
            $error("last: expected %0d, got %0d", want.is_last, last);
            fail_count++;
          end
        end
      end
    end
  end

  task automatic set_reg(input tcc_pkg::reg_idx_t idx, input int unsigned value);
    reg_write_t w;
    w.idx  = idx;
    w.data = tcc_pkg::DATA_W'(value);
    reg_q.push_back(w);
  endtask

  task automatic settle();
    do @(negedge clk);
    while (char_q.size() != 0 || reg_q.size() != 0 || in_valid || cfg_valid ||
           cmd_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [tcc_pkg::CHAR_W-1:0] pick_char();
    int unsigned p;
    p = $urandom_range(0, 9);
    if (p == 0) return tcc_pkg::CHAR_NEWLINE;
    if (p == 1) return tcc_pkg::CHAR_TAB;
    return tcc_pkg::CHAR_W'($urandom_range(0, 255));
  endfunction

  task automatic random_setup(input bit on);
    set_reg(tcc_pkg::REG_ENABLE, on);
    case ($urandom_range(0, 7))
      0: set_reg(tcc_pkg::REG_COLUMNS, 0);
      1: set_reg(tcc_pkg::REG_COLUMNS, 512);
      2: set_reg(tcc_pkg::REG_COLUMNS, 1023);
      3: set_reg(tcc_pkg::REG_COLUMNS, $urandom_range(513, 1023));
      4: set_reg(tcc_pkg::REG_COLUMNS, 1);
      default: set_reg(tcc_pkg::REG_COLUMNS, $urandom_range(2, 12));
    endcase
    case ($urandom_range(0, 7))
      0: set_reg(tcc_pkg::REG_ROWS, 0);
      1: set_reg(tcc_pkg::REG_ROWS, 256);
      2: set_reg(tcc_pkg::REG_ROWS, 511);
      3: set_reg(tcc_pkg::REG_ROWS, $urandom_range(257, 511));
      4: set_reg(tcc_pkg::REG_ROWS, 1);
      default: set_reg(tcc_pkg::REG_ROWS, $urandom_range(2, 6));
    endcase
    case ($urandom_range(0, 4))
      0: set_reg(tcc_pkg::REG_PITCH, 0);
      1: set_reg(tcc_pkg::REG_PITCH, 16383);
      2: set_reg(tcc_pkg::REG_PITCH, 1);
      default: set_reg(tcc_pkg::REG_PITCH, $urandom_range(0, 16383));
    endcase
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // disabled after reset: ignored
    char_q.push_back(8'h41);
    char_q.push_back(tcc_pkg::CHAR_NEWLINE);
    settle();

    set_reg(tcc_pkg::REG_ENABLE, 1);
    settle();
    char_q.push_back(8'h00);
    char_q.push_back(8'hFF);
    char_q.push_back(tcc_pkg::CHAR_TAB);
    char_q.push_back(tcc_pkg::CHAR_NEWLINE);
    settle();

    // tiny screen: wrap, tab wrap with scroll, newline scroll, draw with scroll
    set_reg(tcc_pkg::REG_COLUMNS, 3);
    set_reg(tcc_pkg::REG_ROWS, 2);
    set_reg(tcc_pkg::REG_PITCH, 1);
    settle();
    char_q.push_back(8'h78);
    char_q.push_back(8'h79);
    char_q.push_back(8'h7A);
    char_q.push_back(tcc_pkg::CHAR_TAB);
    char_q.push_back(tcc_pkg::CHAR_NEWLINE);
    char_q.push_back(8'h61);
    char_q.push_back(8'h62);
    char_q.push_back(8'h63);
    settle();

    // park the cursor, then shrink the screen underneath it
    set_reg(tcc_pkg::REG_COLUMNS, 80);
    set_reg(tcc_pkg::REG_ROWS, 25);
    set_reg(tcc_pkg::REG_PITCH, 16383);
    settle();
    repeat (3) char_q.push_back(tcc_pkg::CHAR_NEWLINE);
    repeat (5) char_q.push_back(tcc_pkg::CHAR_TAB);
    settle();
    set_reg(tcc_pkg::REG_COLUMNS, 0);
    set_reg(tcc_pkg::REG_ROWS, 0);
    settle();
    char_q.push_back(8'h51);
    char_q.push_back(8'h52);
    char_q.push_back(tcc_pkg::CHAR_NEWLINE);
    settle();

    // tall wide screen: deep rows, offset wrap
    set_reg(tcc_pkg::REG_COLUMNS, 512);
    set_reg(tcc_pkg::REG_ROWS, 256);
    set_reg(tcc_pkg::REG_PITCH, 16383);
    settle();
    repeat (115) char_q.push_back(($urandom_range(0, 9) != 0) ?
                                  tcc_pkg::CHAR_NEWLINE : pick_char());
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      random_setup(ph != 3);
      settle();
      repeat (45) char_q.push_back(pick_char());
      settle();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("text_console_cursor_blitter_top verification clean");
    end else begin
      $display("text_console_cursor_blitter_top verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("text_console_cursor_blitter_top verification failed");
    $finish;
  end

endmodule
